FILE: src/irpw_pkg.sv
// Shared types and constants for the IR pulse-width frame decoder.
`default_nettype none

package irpw_pkg;

    localparam logic OP_INTERVAL = 1'b0;
    localparam logic OP_RELEASE  = 1'b1;

    localparam int STEP_W = 7;
    localparam logic [STEP_W-1:0] STEP_SYNC_MARK  = 7'd0;
    localparam logic [STEP_W-1:0] STEP_SYNC_SPACE = 7'd1;
    localparam logic [STEP_W-1:0] STEP_FIRST_BIT  = 7'd2;
    localparam logic [STEP_W-1:0] STEP_HELD       = 7'd66;

    localparam logic [15:0] WIN_ANY_LO    = 16'd80;
    localparam logic [15:0] WIN_ANY_HI    = 16'd250;
    localparam logic [15:0] WIN_SMARK_LO  = 16'd120;
    localparam logic [15:0] WIN_SMARK_HI  = 16'd250;
    localparam logic [15:0] WIN_SSPACE_LO = 16'd70;
    localparam logic [15:0] WIN_SSPACE_HI = 16'd100;
    localparam logic [15:0] WIN_BMARK_LO  = 16'd130;
    localparam logic [15:0] WIN_BMARK_HI  = 16'd180;
    localparam logic [15:0] WIN_SHORT_LO  = 16'd80;
    localparam logic [15:0] WIN_SHORT_HI  = 16'd110;
    localparam logic [15:0] WIN_LONG_LO   = 16'd110;
    localparam logic [15:0] WIN_LONG_HI   = 16'd165;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic        opcode;
        logic [15:0] duration;
    } t_in_item;

    typedef struct packed {
        logic        code_ready;
        logic [31:0] code_word;
        logic        frame_error;
    } t_out_item;

    typedef struct packed {
        logic release_op;
        logic in_win;
        logic sync_mark;
        logic sync_space;
        logic bit_mark;
        logic short_space;
        logic long_space;
    } t_cls;

    function automatic logic in_window(input logic [15:0] d, input logic [15:0] lo,
                                       input logic [15:0] hi);
        return (d > lo) && (d < hi);
    endfunction

endpackage

`default_nettype wire

FILE: src/irpw_front.sv
// Front end: classifies each interval beat against the protocol windows.
`default_nettype none

module irpw_front
    import irpw_pkg::*;
(
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_data,
    output logic          o_push,
    output t_cls          o_cls,
    input  wire logic     i_full
);

    assign o_push = i_in_valid && !i_full;

    always_comb begin
        o_cls.release_op  = (i_in_data.opcode == OP_RELEASE);
        o_cls.in_win      = in_window(i_in_data.duration, WIN_ANY_LO, WIN_ANY_HI);
        o_cls.sync_mark   = in_window(i_in_data.duration, WIN_SMARK_LO, WIN_SMARK_HI);
        o_cls.sync_space  = in_window(i_in_data.duration, WIN_SSPACE_LO, WIN_SSPACE_HI);
        o_cls.bit_mark    = in_window(i_in_data.duration, WIN_BMARK_LO, WIN_BMARK_HI);
        o_cls.short_space = in_window(i_in_data.duration, WIN_SHORT_LO, WIN_SHORT_HI);
        o_cls.long_space  = in_window(i_in_data.duration, WIN_LONG_LO, WIN_LONG_HI);
    end

endmodule

`default_nettype wire

FILE: src/irpw_queue.sv
// Short queue of classified beats between front and back end.
`default_nettype none

module irpw_queue
    import irpw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_cls,
    output logic      o_full,
    output logic      o_valid,
    output t_cls      o_cls,
    input  wire logic i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cls   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

FILE: src/irpw_back.sv
// Back end: frame step sequencer, indexed code register and result register.
`default_nettype none

module irpw_back
    import irpw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_cls i_cls,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  wire logic i_out_stall
);

    logic [STEP_W-1:0] r_step, n_step;
    logic [31:0]       r_code, n_code;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;
    logic              abort;
    logic [4:0]        bit_idx;

    assign o_pop       = i_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign bit_idx = r_step[5:1] - 5'd1;

    always_comb begin
        n_step = r_step;
        n_code = r_code;
        abort  = 1'b0;
        if (i_cls.release_op) begin
            n_step = STEP_SYNC_MARK;
            n_code = '0;
        end else if (r_step != STEP_HELD && i_cls.in_win) begin
            if (r_step >= STEP_FIRST_BIT) begin
                if (r_step[0]) begin
                    if (i_cls.short_space) begin
                        n_code[bit_idx] = 1'b0;
                        n_step = r_step + 1'b1;
                    end else if (i_cls.long_space) begin
                        n_code[bit_idx] = 1'b1;
                        n_step = r_step + 1'b1;
                    end else begin
                        abort = 1'b1;
                    end
                end else if (i_cls.bit_mark) begin
                    n_step = r_step + 1'b1;
                end else begin
                    abort = 1'b1;
                end
            end else if (r_step == STEP_SYNC_SPACE) begin
                if (i_cls.sync_space) begin
                    n_step = STEP_FIRST_BIT;
                end else begin
                    abort = 1'b1;
                end
            end else if (i_cls.sync_mark) begin
                n_step = STEP_SYNC_SPACE;
            end
            if (abort) begin
                n_code = '0;
                n_step = i_cls.sync_mark ? STEP_SYNC_SPACE : STEP_SYNC_MARK;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (o_pop) begin
            n_out_valid           = 1'b1;
            n_out.code_ready      = (n_step == STEP_HELD);
            n_out.code_word       = (n_step == STEP_HELD) ? n_code : '0;
            n_out.frame_error     = abort;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_SYNC_MARK;
            r_code      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_step <= n_step;
                r_code <= n_code;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_HELD) else $error("frame step out of range");
    a_ready_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.code_ready |-> r_step == STEP_HELD)
        else $error("code shown ready while not held");
    a_error_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_error |-> !r_out.code_ready)
        else $error("aborted frame shown ready");
    a_held_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == STEP_HELD && !(o_pop && i_cls.release_op) |=> r_step == STEP_HELD)
        else $error("held code dropped without release");
`endif

endmodule

`default_nettype wire

FILE: src/ir_pulse_width_frame_decoder_core.sv
// Top level of the IR pulse-width frame decoder.
//
//   channel  direction  payload     handshake
//   in       input      t_in_item   i_in_valid / o_in_stall
//   out      output     t_out_item  o_out_valid / i_out_stall
//
// One beat per cycle sustained while the output is not stalled; a result is presented
// after its input beat is accepted, passes through the queue and is then loaded into the result register.
// The back-end step register is updated once per beat.
// Reset is synchronous; it clears the frame step, the code and the queue.
// A stalled output fills the queue, and input stall rises when the queue is full.
`default_nettype none

module ir_pulse_width_frame_decoder_core
    import irpw_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_data
);

    logic push;
    logic full;
    t_cls front_cls;
    logic q_valid;
    t_cls q_cls;
    logic pop;

    assign o_in_stall = full;

    irpw_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_cls      (front_cls),
        .i_full     (full)
    );

    irpw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (front_cls),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cls   (q_cls),
        .i_pop   (pop)
    );

    irpw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cls       (q_cls),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
